// ===== rtl/core/sapq_pkg.sv =====
package sapq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam logic [7:0] VIP_PRIORITY = 8'd0;

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_PEEK    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS_CMP,
		S_INS_PUT,
		S_RD_WAIT
	} state_t;

	// read address source
	typedef enum logic [1:0] {
		RA_TAIL,
		RA_HEAD,
		RA_PREV
	} rd_sel_t;

	// write address and data source
	typedef enum logic [1:0] {
		WR_SHIFT_UP,
		WR_NEW_NEXT,
		WR_NEW_HEAD
	} wr_sel_t;

	typedef struct packed {
		logic    cap;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    fill_inc;
		logic    fill_dec;
		logic    res_load;
		status_t res_status;
		logic    res_entry;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic gt;
		logic cur_zero;
	} dp_stat_t;

endpackage

// ===== rtl/core/sapq_ctrl.sv =====
module sapq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sapq_pkg::dp_stat_t stat,
	output logic               busy,
	output sapq_pkg::dp_cmd_t  dcmd
);

	sapq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sapq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		dcmd            = '0;
		dcmd.rd_sel     = sapq_pkg::RA_TAIL;
		dcmd.wr_sel     = sapq_pkg::WR_NEW_HEAD;
		dcmd.res_status = sapq_pkg::ST_OK;
		busy            = 1'b1;
		case (state_q)
			sapq_pkg::S_IDLE: begin
				busy     = 1'b0;
				dcmd.cap = start;
				if (start) begin
					state_d = sapq_pkg::S_DECODE;
				end
			end
			sapq_pkg::S_DECODE: begin
				state_d = sapq_pkg::S_IDLE;
				case (stat.cmd)
					sapq_pkg::CMD_INSERT: begin
						if (stat.full) begin
							dcmd.res_load   = 1'b1;
							dcmd.res_status = sapq_pkg::ST_FULL;
						end else if (stat.empty) begin
							dcmd.wr_en    = 1'b1;
							dcmd.wr_sel   = sapq_pkg::WR_NEW_HEAD;
							dcmd.fill_inc = 1'b1;
							dcmd.res_load = 1'b1;
						end else begin
							// start the backward walk at the tail
							dcmd.rd_en  = 1'b1;
							dcmd.rd_sel = sapq_pkg::RA_TAIL;
							state_d     = sapq_pkg::S_INS_CMP;
						end
					end
					sapq_pkg::CMD_EXTRACT, sapq_pkg::CMD_PEEK: begin
						if (stat.empty) begin
							dcmd.res_load   = 1'b1;
							dcmd.res_status = sapq_pkg::ST_EMPTY;
						end else begin
							dcmd.rd_en = 1'b1;
							if (stat.cmd == sapq_pkg::CMD_EXTRACT) begin
								dcmd.rd_sel   = sapq_pkg::RA_TAIL;
								dcmd.fill_dec = 1'b1;
							end else begin
								dcmd.rd_sel = sapq_pkg::RA_HEAD;
							end
							state_d = sapq_pkg::S_RD_WAIT;
						end
					end
					default: begin
						dcmd.res_load = 1'b1;
					end
				endcase
			end
			sapq_pkg::S_INS_CMP: begin
				dcmd.wr_en = 1'b1;
				if (stat.gt) begin
					// move the larger entry up one slot
					dcmd.wr_sel = sapq_pkg::WR_SHIFT_UP;
					if (stat.cur_zero) begin
						state_d = sapq_pkg::S_INS_PUT;
					end else begin
						dcmd.rd_en  = 1'b1;
						dcmd.rd_sel = sapq_pkg::RA_PREV;
					end
				end else begin
					dcmd.wr_sel   = sapq_pkg::WR_NEW_NEXT;
					dcmd.fill_inc = 1'b1;
					dcmd.res_load = 1'b1;
					state_d       = sapq_pkg::S_IDLE;
				end
			end
			sapq_pkg::S_INS_PUT: begin
				dcmd.wr_en    = 1'b1;
				dcmd.wr_sel   = sapq_pkg::WR_NEW_HEAD;
				dcmd.fill_inc = 1'b1;
				dcmd.res_load = 1'b1;
				state_d       = sapq_pkg::S_IDLE;
			end
			sapq_pkg::S_RD_WAIT: begin
				dcmd.res_load  = 1'b1;
				dcmd.res_entry = 1'b1;
				state_d        = sapq_pkg::S_IDLE;
			end
			default: begin
				state_d = sapq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/sapq_dp.sv =====
module sapq_dp #(
	parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEF,
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         cmd,
	input  logic [15:0]        client,
	input  logic [7:0]         priority_req,
	input  sapq_pkg::dp_cmd_t  dcmd,
	output sapq_pkg::dp_stat_t stat,
	output logic               done,
	output logic [1:0]         status,
	output logic [15:0]        out_client,
	output logic [7:0]         out_priority,
	output logic               out_vip,
	output logic [FW-1:0]      fill
);

	logic [15:0] mem_cid [QUEUE_DEPTH];
	logic [7:0]  mem_pri [QUEUE_DEPTH];

	sapq_pkg::cmd_t cmd_q;
	logic [15:0]    cid_q;
	logic [7:0]     pri_q;
	logic [FW-1:0]  fill_q;
	logic [AW-1:0]  cur_q;
	logic [15:0]    rd_cid_q;
	logic [7:0]     rd_pri_q;

	logic           done_q;
	logic [1:0]     status_q;
	logic [15:0]    out_client_q;
	logic [7:0]     out_priority_q;
	logic           out_vip_q;

	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;
	logic [15:0]    wr_cid;
	logic [7:0]     wr_pri;
	logic [FW-1:0]  fill_m1;

	assign fill_m1 = fill_q - FW'(1);

	always_comb begin
		case (dcmd.rd_sel)
			sapq_pkg::RA_TAIL: rd_addr = fill_m1[AW-1:0];
			sapq_pkg::RA_HEAD: rd_addr = '0;
			sapq_pkg::RA_PREV: rd_addr = cur_q - AW'(1);
			default:           rd_addr = '0;
		endcase
	end

	always_comb begin
		case (dcmd.wr_sel)
			sapq_pkg::WR_SHIFT_UP: begin
				wr_addr = cur_q + AW'(1);
				wr_cid  = rd_cid_q;
				wr_pri  = rd_pri_q;
			end
			sapq_pkg::WR_NEW_NEXT: begin
				wr_addr = cur_q + AW'(1);
				wr_cid  = cid_q;
				wr_pri  = pri_q;
			end
			default: begin
				wr_addr = '0;
				wr_cid  = cid_q;
				wr_pri  = pri_q;
			end
		endcase
	end

	// storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (dcmd.wr_en) begin
			mem_cid[wr_addr] <= wr_cid;
			mem_pri[wr_addr] <= wr_pri;
		end
		if (dcmd.rd_en) begin
			rd_cid_q <= mem_cid[rd_addr];
			rd_pri_q <= mem_pri[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.cap) begin
			cmd_q <= sapq_pkg::cmd_t'(cmd);
			cid_q <= client;
			pri_q <= priority_req;
		end
		if (dcmd.rd_en) begin
			cur_q <= rd_addr;
		end
		if (dcmd.res_load) begin
			status_q <= dcmd.res_status;
			if (dcmd.res_entry) begin
				out_client_q   <= rd_cid_q;
				out_priority_q <= rd_pri_q;
				out_vip_q      <= (rd_pri_q == sapq_pkg::VIP_PRIORITY);
			end else begin
				out_client_q   <= '0;
				out_priority_q <= '0;
				out_vip_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= dcmd.res_load;
			if (dcmd.fill_inc) begin
				fill_q <= fill_q + FW'(1);
			end else if (dcmd.fill_dec) begin
				fill_q <= fill_m1;
			end
		end
	end

	assign stat.cmd      = cmd_q;
	assign stat.empty    = (fill_q == '0);
	assign stat.full     = (fill_q == FW'(QUEUE_DEPTH));
	assign stat.gt       = (rd_pri_q > pri_q);
	assign stat.cur_zero = (cur_q == '0);

	assign done         = done_q;
	assign status       = status_q;
	assign out_client   = out_client_q;
	assign out_priority = out_priority_q;
	assign out_vip      = out_vip_q;
	assign fill         = fill_q;

endmodule

// ===== rtl/core/sorted_array_priority_queue.sv =====
// Sorted-array priority queue. Entries (client id, priority) are kept in ascending
// priority order, older entries first among equals. Raise start with cmd, client
// and priority_req while busy is low to issue a transaction: insert (after every
// entry of lower or equal priority, or status full), extract (remove and return the
// tail, which holds the largest priority value), or peek (return the head without
// removing it); extract or peek on an empty queue returns status empty. Each
// transaction gives exactly one result, shown for a single cycle with done high;
// the receiver cannot stall, so capture it on that cycle. fill is the entry count
// after the transaction. A rejected command (insert when full, extract or peek when
// empty, the unused command code) and an insert into an empty queue are answered
// from the decode state; extract and peek read the entry there and answer from the
// read-wait state; an insert into stored entries walks back from the tail in the
// compare state, moving each larger entry up one slot, one entry per cycle through
// the entry memory's single read port and single write port, then writes the new
// entry above the first entry that is not larger, or at the head from the put state.
// A new transaction may be accepted in the cycle done is high, which is registered
// from the answering state.
module sorted_array_priority_queue #(
	parameter int QUEUE_DEPTH = sapq_pkg::QUEUE_DEPTH_DEF,
	localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    cmd,
	input  logic [15:0]   client,
	input  logic [7:0]    priority_req,
	output logic          done,
	output logic [1:0]    status,
	output logic [15:0]   out_client,
	output logic [7:0]    out_priority,
	output logic          out_vip,
	output logic [FW-1:0] fill
);

	sapq_pkg::dp_cmd_t  dcmd;
	sapq_pkg::dp_stat_t stat;

	// sequencer: decode, walk, write, respond
	sapq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.dcmd   (dcmd)
	);

	// entry memory, fill count, request and result registers
	sapq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.client       (client),
		.priority_req (priority_req),
		.dcmd         (dcmd),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.out_client   (out_client),
		.out_priority (out_priority),
		.out_vip      (out_vip),
		.fill         (fill)
	);

	// a result always follows a transaction in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	// an accepted transaction holds off the next one
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after accept");

	// full is reported only when the store is really full
	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == sapq_pkg::ST_FULL) |-> (fill == FW'(QUEUE_DEPTH)))
		else $error("full status with free slots");

	// empty is reported only when nothing is stored
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == sapq_pkg::ST_EMPTY) |-> (fill == '0))
		else $error("empty status with stored entries");

	// fill count stays within the store
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FW'(QUEUE_DEPTH))
		else $error("fill count beyond depth");

endmodule
